### hdl/sparse_row_index_sorter_macros.svh
// Assertion helpers used by the bound checker module.
`ifndef SPARSE_ROW_INDEX_SORTER_MACROS_SVH
`define SPARSE_ROW_INDEX_SORTER_MACROS_SVH

// Clocked property, masked while reset is held.
`define SRIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define SRIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/srisort_pkg.sv
package srisort_pkg;

    localparam int IndexWidth    = 16;
    localparam int ValueWidth    = 64;
    localparam int MaxRowEntries = 64;

    typedef struct packed {
        logic [IndexWidth-1:0] row_number;
        logic [IndexWidth-1:0] column;
        logic [ValueWidth-1:0] value_bits;
        logic                  row_end;
    } t_in_beat;

    typedef struct packed {
        logic [IndexWidth-1:0] out_column;
        logic [ValueWidth-1:0] out_value_bits;
        logic                  out_last;
        logic                  row_overflow;
    } t_out_beat;

    typedef struct packed {
        logic [IndexWidth-1:0] column;
        logic [ValueWidth-1:0] value_bits;
    } t_entry;

endpackage

### hdl/srisort_queue.sv
// Two-beat queue between the input port and the sorting chain.
module srisort_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  srisort_pkg::t_in_beat i_data,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output srisort_pkg::t_in_beat o_q_data
);

    srisort_pkg::t_in_beat r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_slot[r_rptr];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

### hdl/srisort_chain.sv
// Insertion chain: one entry a cycle goes into sorted place, then the row shifts
// out of cell 0 one beat a cycle unless stalled, with the diagonal swap applied.
module srisort_chain #(
    parameter int MAX_ROW_ENTRIES = srisort_pkg::MaxRowEntries
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  srisort_pkg::t_in_beat  i_q_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output srisort_pkg::t_out_beat o_data
);

    localparam int CntW = $clog2(MAX_ROW_ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state                r_state;
    srisort_pkg::t_entry   r_cell [MAX_ROW_ENTRIES];
    srisort_pkg::t_entry   n_cell [MAX_ROW_ENTRIES];
    logic [MAX_ROW_ENTRIES-1:0] le;
    logic [CntW-1:0]       r_count;
    logic [CntW-1:0]       r_k;
    logic [srisort_pkg::IndexWidth-1:0] r_row;
    logic                  r_ovf;
    logic                  r_found;
    srisort_pkg::t_entry   r_last;
    srisort_pkg::t_entry   r_diag;
    srisort_pkg::t_entry   new_ent;
    srisort_pkg::t_entry   emit_ent;
    logic                  r_ovalid;
    srisort_pkg::t_out_beat r_odata;
    logic                  pop;
    logic                  full;
    logic                  ins;
    logic                  do_emit;
    logic                  last_pos;
    logic                  take_diag;

    assign pop      = (r_state == ST_LOAD) && i_q_valid;
    assign o_q_pop  = pop;
    assign full     = (r_count == CntW'(MAX_ROW_ENTRIES));
    assign ins      = pop && !full;
    assign do_emit  = (r_state == ST_EMIT) && (!r_ovalid || !i_stall);
    assign last_pos = (r_k == r_count - CntW'(1));
    assign new_ent  = '{column: i_q_data.column, value_bits: i_q_data.value_bits};
    // first diagonal not already last: send the row's last entry here instead
    assign take_diag = !r_found && (r_cell[0].column == r_row) && !last_pos;

    always_comb begin
        if (take_diag) begin
            emit_ent = r_last;
        end else if (last_pos && r_found) begin
            emit_ent = r_diag;
        end else begin
            emit_ent = r_cell[0];
        end
    end

    // stable: new entry goes after every kept entry with column <= key
    for (genvar gi = 0; gi < MAX_ROW_ENTRIES; gi++) begin : g_cell
        assign le[gi] = (CntW'(gi) < r_count) && (r_cell[gi].column <= new_ent.column);
        always_comb begin
            n_cell[gi] = r_cell[gi];
            if (ins) begin
                if (le[gi]) begin
                    n_cell[gi] = r_cell[gi];
                end else if (gi == 0) begin
                    n_cell[gi] = new_ent;
                end else if (le[(gi == 0) ? 0 : gi-1]) begin
                    n_cell[gi] = new_ent;
                end else begin
                    n_cell[gi] = r_cell[(gi == 0) ? 0 : gi-1];
                end
            end else if (do_emit) begin
                n_cell[gi] = r_cell[(gi == MAX_ROW_ENTRIES-1) ? gi : gi+1];
            end
        end
        always_ff @(posedge i_clk) begin
            r_cell[gi] <= n_cell[gi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_k      <= '0;
            r_row    <= '0;
            r_ovf    <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (do_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (pop) begin
                        r_row <= i_q_data.row_number;
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CntW'(1);
                        end
                        if (i_q_data.row_end) begin
                            r_state <= ST_EMIT;
                            r_k     <= '0;
                        end
                    end
                end
                ST_EMIT: begin
                    if (do_emit) begin
                        r_k <= r_k + CntW'(1);
                        if (take_diag) begin
                            r_found <= 1'b1;
                        end
                        if (last_pos) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_found <= 1'b0;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins && ((r_count == '0) || (new_ent.column >= r_last.column))) begin
            r_last <= new_ent;
        end
        if (do_emit && take_diag) begin
            r_diag <= r_cell[0];
        end
        if (do_emit) begin
            r_odata.out_column     <= emit_ent.column;
            r_odata.out_value_bits <= emit_ent.value_bits;
            r_odata.out_last       <= last_pos;
            r_odata.row_overflow   <= r_ovf;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

### hdl/sparse_row_index_sorter.sv
// Sorts the entries of one sparse row by column (stable) and emits them with
// the first diagonal entry swapped into last place. Entries are taken one a
// cycle while the chain loads, into an insertion chain of MAX_ROW_ENTRIES
// cells; the row_end beat starts emission, one beat a cycle from the chain
// head unless the receiver stalls. The single-port chain either loads or
// shifts out, not both; entries past capacity are dropped and flag the row.
module sparse_row_index_sorter #(
    parameter int MAX_ROW_ENTRIES = srisort_pkg::MaxRowEntries
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  srisort_pkg::t_in_beat  i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output srisort_pkg::t_out_beat o_data
);

    logic                  q_valid;
    logic                  q_pop;
    srisort_pkg::t_in_beat q_data;

    srisort_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_data  (q_data)
    );

    srisort_chain #(
        .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_data  (q_data),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

### hdl/srisort_checker.sv
`include "sparse_row_index_sorter_macros.svh"

module srisort_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input srisort_pkg::t_in_beat  i_data,
    input logic                   o_valid,
    input logic                   i_stall,
    input srisort_pkg::t_out_beat o_data
);

    `SRIS_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_data), "stalled beat changed")
    `SRIS_ASSERT(a_ovf_row, o_valid && !i_stall && !o_data.out_last |=> !o_valid || (o_data.row_overflow == $past(o_data.row_overflow)), "overflow flag changed within a row")
    `SRIS_ASSERT(a_stall_rise, $rose(o_stall) |-> $past(i_valid), "queue filled without an input beat")

endmodule

bind sparse_row_index_sorter srisort_checker u_srisort_checker (.*);

### tb/sparse_row_index_sorter_checker.sv
module sparse_row_index_sorter_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_in_stall,
    input  srisort_pkg::t_in_beat  i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_stall,
    input  srisort_pkg::t_out_beat i_out_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    srisort_pkg::t_entry    held_entries[srisort_pkg::MaxRowEntries];
    int                     held_count;
    logic                   dropped_seen;
    srisort_pkg::t_out_beat sorted_beats[$];

    assign o_pending = sorted_beats.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch: %s got %h want %h", what, got, want);
        o_fail_count++;
    endtask

    // Stable insertion sort, then the first diagonal entry swaps with the last.
    task automatic close_row(input logic [srisort_pkg::IndexWidth-1:0] diag_row);
        srisort_pkg::t_entry    key;
        srisort_pkg::t_entry    tmp;
        srisort_pkg::t_out_beat ob;
        int                     pos;
        for (int i = 1; i < held_count; i++) begin
            key = held_entries[i];
            pos = i;
            while (pos > 0 && held_entries[pos-1].column > key.column) begin
                held_entries[pos] = held_entries[pos-1];
                pos--;
            end
            held_entries[pos] = key;
        end
        for (int k = 0; k < held_count; k++) begin
            if (held_entries[k].column == diag_row) begin
                tmp = held_entries[k];
                held_entries[k] = held_entries[held_count-1];
                held_entries[held_count-1] = tmp;
                break;
            end
        end
        for (int k = 0; k < held_count; k++) begin
            ob.out_column     = held_entries[k].column;
            ob.out_value_bits = held_entries[k].value_bits;
            ob.out_last       = (k == held_count - 1);
            ob.row_overflow   = dropped_seen;
            sorted_beats.push_back(ob);
        end
        held_count   = 0;
        dropped_seen = 1'b0;
    endtask

    always @(posedge i_clk) begin
        srisort_pkg::t_out_beat want;
        if (!i_rst_n) begin
            held_count   = 0;
            dropped_seen = 1'b0;
            o_fail_count = 0;
            sorted_beats.delete();
        end else begin
            if (i_out_valid && !i_stall) begin
                if (sorted_beats.size() == 0) begin
                    report("unexpected beat", 64'(i_out_data.out_column), '0);
                end else begin
                    want = sorted_beats.pop_front();
                    if (i_out_data.out_column !== want.out_column)
                        report("out_column", 64'(i_out_data.out_column),
                               64'(want.out_column));
                    if (i_out_data.out_value_bits !== want.out_value_bits)
                        report("out_value_bits", i_out_data.out_value_bits,
                               want.out_value_bits);
                    if (i_out_data.out_last !== want.out_last)
                        report("out_last", 64'(i_out_data.out_last), 64'(want.out_last));
                    if (i_out_data.row_overflow !== want.row_overflow)
                        report("row_overflow", 64'(i_out_data.row_overflow),
                               64'(want.row_overflow));
                end
            end
            if (i_valid && !i_in_stall) begin
                if (held_count < srisort_pkg::MaxRowEntries) begin
                    held_entries[held_count] = '{i_in_data.column, i_in_data.value_bits};
                    held_count++;
                end else begin
                    dropped_seen = 1'b1;
                end
                if (i_in_data.row_end)
                    close_row(i_in_data.row_number);
            end
        end
    end
endmodule

### tb/sparse_row_index_sorter_test.sv
module sparse_row_index_sorter_test;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    srisort_pkg::t_in_beat  in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    srisort_pkg::t_out_beat out_data;
    int                     fail_count;
    int                     pending;
    int                     cycle_count = 0;
    bit                     calm_tail = 1'b0;
    bit                     hold_off = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sparse_row_index_sorter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data)
    );

    sparse_row_index_sorter_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("sparse_row_index_sorter test failed");
            $finish;
        end
    end

    // Receiver stalls: random bursts, one long hold-off, none at the tail.
    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // One beat; caller is at a falling edge. Leaves valid high, returns after accept.
    task automatic send_beat(input logic [15:0] row, input logic [15:0] col,
                             input logic [63:0] val, input logic last);
        int gap;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{row, col, val, last};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_row(input int count, input logic [15:0] row, input int col_span);
        logic [15:0] col;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0)
                col = row;
            else
                col = 16'($urandom_range(0, col_span));
            send_beat(row, col, rand_value(), i == count - 1);
        end
    endtask

    initial begin
        int sent;
        int count;
        logic [15:0] row;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single entry, field extremes, diagonal first / last / absent.
        send_beat(16'hffff, 16'hffff, '1, 1'b1);
        send_beat(16'h0000, 16'h0000, '0, 1'b1);
        send_beat(16'd5, 16'd5, 64'h1, 1'b0);
        send_beat(16'd5, 16'd9, 64'h2, 1'b0);
        send_beat(16'd5, 16'd2, 64'h3, 1'b1);
        send_beat(16'd3, 16'd1, 64'h4, 1'b0);
        send_beat(16'd3, 16'd3, 64'h5, 1'b1);
        send_beat(16'd7, 16'd4, 64'h6, 1'b0);
        send_beat(16'd7, 16'd4, 64'h7, 1'b0);
        send_beat(16'd7, 16'd0, 64'h8, 1'b1);
        // mixed row numbers: the closing beat decides the diagonal
        send_beat(16'd1, 16'd8, 64'h9, 1'b0);
        send_beat(16'd8, 16'd1, 64'ha, 1'b1);
        // row full with the closing beat dropped
        for (int i = 0; i < 66; i++)
            send_beat(16'd20, 16'($urandom_range(0, 40)), rand_value(), i == 65);

        sent = 0;
        hold_off = 1'b1;
        while (sent < 265) begin
            if (sent > 200) calm_tail = 1'b1;
            row = $urandom_range(0, 9) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 15));
            count = $urandom_range(0, 12) == 0 ? $urandom_range(60, 68) : $urandom_range(1, 8);
            send_row(count, row, $urandom_range(0, 1) ? 15 : 65535);
            sent += count;
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("sparse_row_index_sorter test passed");
        else
            $display("sparse_row_index_sorter test failed");
        $finish;
    end
endmodule
